// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the radix text converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/itr_pkg.sv =====
// Types and character constants of the radix text converter.
package itr_pkg;

  // Input beat: value, radix and signed-mode flag
  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  radix;
    logic        signed_mode;
  } in_t;

  // Output beat: one character of the text
  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
    logic       bad_radix;
  } out_t;

  // Classified command passed from front to back (magnitude travels apart)
  typedef struct packed {
    logic [5:0] radix;
    logic       neg;
    logic       bad;
  } cmd_t;

  localparam int unsigned VALUE_IN_W = 32;
  localparam logic [5:0]  RADIX_MIN  = 6'd2;
  localparam logic [5:0]  RADIX_MAX  = 6'd36;
  localparam logic [5:0]  RADIX_DEC  = 6'd10;
  localparam logic [5:0]  DIGIT_MAX  = 6'd9;

  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CH_MINUS   = 8'h2D;  // '-'
  localparam logic [7:0] CH_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;  // 'z'
  localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_NONE    = 8'h00;

endpackage

// ===== rtl/core/itr_front.sv =====
// Front end: accepts input beats, classifies them and queues commands.
module itr_front #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  itr_pkg::in_t           in_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output logic [VALUE_WIDTH-1:0] cmd_mag_o,
  output itr_pkg::cmd_t          cmd_o
);
  import itr_pkg::*;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  logic [VALUE_WIDTH-1:0] val;
  logic [VALUE_WIDTH-1:0] mag;
  cmd_t                   cmd_new;
  logic                   push;
  logic                   pop;

  logic [VALUE_WIDTH-1:0] mag_q [QDEPTH];
  cmd_t                   ctl_q [QDEPTH];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]       count_q, count_d;

  // Classify: mask to width, range-check radix, take magnitude of negatives
  always_comb begin
    val             = VALUE_WIDTH'(in_i.value);
    cmd_new.radix   = in_i.radix;
    cmd_new.bad     = !(in_i.radix inside {[RADIX_MIN:RADIX_MAX]});
    cmd_new.neg     = in_i.signed_mode && (in_i.radix == RADIX_DEC) && val[VALUE_WIDTH-1];
    mag             = cmd_new.neg ? (VALUE_WIDTH'(0) - val) : val;
  end

  assign in_ready_o  = (count_q != CNT_W'(QDEPTH));
  assign cmd_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_mag_o   = mag_q[rd_ptr_q];
  assign cmd_o       = ctl_q[rd_ptr_q];

  // Queue pointers and fill count
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mag_q[wr_ptr_q] <= mag;
      ctl_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== rtl/core/itr_div.sv =====
// Iterative divider by a small radix, eight quotient bits per cycle.
module itr_div #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [VALUE_WIDTH-1:0] dividend_i,
  input  logic [5:0]             radix_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] quot_o,
  output logic [5:0]             rem_o
);
  import itr_pkg::*;

  localparam int unsigned BPC   = 8;
  localparam int unsigned PADW  = ((VALUE_WIDTH + BPC - 1) / BPC) * BPC;
  localparam int unsigned STEPS = PADW / BPC;
  localparam int unsigned CNT_W = $clog2(STEPS + 1);

  logic [PADW-1:0]  sh_q, sh_d;
  logic [5:0]       rem_q, rem_d;
  logic [5:0]       radix_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [6:0]       trial;

  // Eight restoring-division steps: dividend bits leave at the top,
  // quotient bits enter at the bottom of the same register
  always_comb begin
    rem_d = rem_q;
    sh_d  = sh_q;
    trial = '0;
    for (int k = 0; k < BPC; k++) begin
      trial = {rem_d, sh_d[PADW-1]};
      sh_d  = {sh_d[PADW-2:0], 1'b0};
      if (trial >= {1'b0, radix_q}) begin
        rem_d   = 6'(trial - {1'b0, radix_q});
        sh_d[0] = 1'b1;
      end else begin
        rem_d = trial[5:0];
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q    <= PADW'(dividend_i);
      rem_q   <= '0;
      radix_q <= radix_i;
    end else if (busy_q) begin
      sh_q  <= sh_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q[VALUE_WIDTH-1:0];
  assign rem_o  = rem_q;

endmodule

// ===== rtl/core/itr_back.sv =====
// Back end: divides down the magnitude, stores digits, emits characters.
module itr_back #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_DIGITS  = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cmd_valid_i,
  output logic                   cmd_ready_o,
  input  logic [VALUE_WIDTH-1:0] cmd_mag_i,
  input  itr_pkg::cmd_t          cmd_i,
  input  logic                   letter_case_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output itr_pkg::out_t          out_o
);
  import itr_pkg::*;

  localparam int unsigned AW    = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SIGN = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   neg_q, neg_d;
  logic [5:0]             radix_q, radix_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;
  logic                   out_free;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [5:0]             div_radix;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quot;
  logic [5:0]             div_rem;

  logic                   mem_we;
  logic                   mem_re;
  logic [5:0]             digit_mem [MAX_DIGITS];
  logic [5:0]             rd_digit_q;

  function automatic logic [7:0] digit_char(logic [5:0] d, logic upper);
    logic [7:0] base;
    base = upper ? CH_UPPER_A : CH_LOWER_A;
    if (d > DIGIT_MAX) begin
      return base + 8'(d) - 8'(RADIX_DEC);
    end
    return CH_ZERO + 8'(d);
  endfunction

  itr_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .radix_i   (div_radix),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign out_free = !out_valid_q || out_ready_i;

  // Sequencer: divide loop, then sign, then digits most significant first; a bad radix gives one flagged beat
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    neg_d        = neg_q;
    radix_d      = radix_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    cmd_ready_o  = 1'b0;
    div_start    = 1'b0;
    div_dividend = cmd_mag_i;
    div_radix    = cmd_i.radix;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.bad) begin
            if (out_free) begin
              cmd_ready_o     = 1'b1;
              out_valid_d     = 1'b1;
              out_d.char_code = CH_NONE;
              out_d.last      = 1'b1;
              out_d.bad_radix = 1'b1;
            end
          end else begin
            cmd_ready_o = 1'b1;
            div_start   = 1'b1;
            neg_d       = cmd_i.neg;
            radix_d     = cmd_i.radix;
            cnt_d       = '0;
            state_d     = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        div_dividend = div_quot;
        div_radix    = radix_q;
        if (div_done) begin
          mem_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
          if ((div_quot != '0) && (cnt_q < CNT_W'(MAX_DIGITS - 1))) begin
            div_start = 1'b1;
          end else begin
            state_d = neg_q ? ST_SIGN : ST_RD;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.char_code = CH_MINUS;
          out_d.last      = 1'b0;
          out_d.bad_radix = 1'b0;
          state_d         = ST_RD;
        end
      end
      ST_RD: begin
        mem_re  = 1'b1;
        cnt_d   = cnt_q - CNT_W'(1);
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.char_code = digit_char(rd_digit_q, letter_case_i);
          out_d.last      = (cnt_q == '0);
          out_d.bad_radix = 1'b0;
          state_d         = (cnt_q == '0) ? ST_IDLE : ST_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    radix_q <= radix_d;
    out_q   <= out_d;
  end

  // Digit store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[cnt_q[AW-1:0]] <= div_rem;
    end
    if (mem_re) begin
      rd_digit_q <= digit_mem[cnt_d[AW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/core/integer_to_radix_text.sv =====
// Top level of the integer to radix text converter.
//
//   channel  direction  handshake                beat
//   in       input      in_valid_i / in_ready_o  value, radix, signed_mode
//   out      output     out_valid_o / out_ready_i  char_code, last, bad_radix
//   cfg      input      cfg_valid_i / cfg_ready_o  letter_case (cfg_data_i)
//
// Each digit comes from the divide unit (8 quotient bits per cycle), then passes through
// the digit store (one write port, one registered read port); the sign is a single beat.
// A bad radix gives its single flagged beat.
// The front queue holds two numbers, so input keeps flowing while the back works.
// Reset is asynchronous, active low; the digit store needs no clearing.
// An output stall holds the back end; the output register keeps the beat.
`include "assert_macros.svh"

module integer_to_radix_text #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_DIGITS  = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  itr_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output itr_pkg::out_t out_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i
);
  import itr_pkg::*;

  logic                   letter_case_q;
  logic                   cmd_valid;
  logic                   cmd_ready;
  logic [VALUE_WIDTH-1:0] cmd_mag;
  cmd_t                   cmd;

  logic                   bad_beat;
  logic                   bad_form_ok;
  logic                   minus_beat;
  logic                   out_is_minus;
  logic                   out_is_digit;
  logic                   out_is_letter;
  logic                   char_ok;

  // Configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_case_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      letter_case_q <= cfg_data_i;
    end
  end

  itr_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_mag_o  (cmd_mag),
    .cmd_o      (cmd)
  );

  itr_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_mag_i    (cmd_mag),
    .cmd_i        (cmd),
    .letter_case_i(letter_case_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o)
  );

  // Output beat classification for the checks
  assign bad_beat      = out_valid_o && out_o.bad_radix;
  assign bad_form_ok   = out_o.last && (out_o.char_code == CH_NONE);
  assign out_is_minus  = (out_o.char_code == CH_MINUS);
  assign minus_beat    = out_valid_o && out_is_minus;
  assign out_is_digit  = (out_o.char_code >= CH_ZERO) && (out_o.char_code <= CH_NINE);
  assign out_is_letter = ((out_o.char_code >= CH_LOWER_A) && (out_o.char_code <= CH_LOWER_Z)) ||
                         ((out_o.char_code >= CH_UPPER_A) && (out_o.char_code <= CH_UPPER_Z));
  assign char_ok       = out_is_minus || out_is_digit || out_is_letter;

  // Checks
  `ASSERT_IMPL(a_bad_beat_form, bad_beat, bad_form_ok, "bad radix beat must be a lone NUL")
  `ASSERT_IMPL(a_minus_not_last, minus_beat, !out_o.last && !out_o.bad_radix, "sign leads digits")
  `ASSERT_ALWAYS(a_char_set, !out_valid_o || out_o.bad_radix || char_ok, "char outside digit set")

endmodule

// ===== bench/integer_to_radix_text_tb.sv =====
// Self-checking testbench for the integer to radix text converter: directed table, then random.
`timescale 1ns / 100ps

module integer_to_radix_text_tb;
  import itr_pkg::*;

  localparam int unsigned MAX_DIGITS  = 32;
  localparam int unsigned IDLE_PCT    = 11;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned CFG_SETTLE  = 8;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 51;
  localparam int unsigned DIR_ROWS    = 25;
  localparam int unsigned MAX_REPORTS = 20;

  // How a directed row's text is checked
  typedef enum logic [1:0] {
    CHK_PREDICT,
    CHK_TEXT,
    CHK_BAD_RADIX
  } chk_kind_e;

  typedef struct {
    logic [31:0] value;
    logic [5:0]  radix;
    logic        signed_mode;
    logic        upper;
    chk_kind_e   kind;
    string       text;
  } dir_row_t;

  // Directed rows: extremes, sign handling, letter digits, out-of-range radix
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{32'h0000_0000, 6'd10, 1'b0, 1'b0, CHK_TEXT,      "0"},
    '{32'h0000_0000, 6'd2,  1'b0, 1'b0, CHK_TEXT,      "0"},
    '{32'h0000_0009, 6'd10, 1'b0, 1'b0, CHK_TEXT,      "9"},
    '{32'hFFFF_FFFF, 6'd10, 1'b0, 1'b0, CHK_TEXT,      "4294967295"},
    '{32'hFFFF_FFFF, 6'd10, 1'b1, 1'b0, CHK_TEXT,      "-1"},
    '{32'h8000_0000, 6'd10, 1'b1, 1'b0, CHK_TEXT,      "-2147483648"},
    '{32'h7FFF_FFFF, 6'd10, 1'b1, 1'b0, CHK_TEXT,      "2147483647"},
    '{32'h8000_0000, 6'd10, 1'b0, 1'b0, CHK_TEXT,      "2147483648"},
    '{32'h8000_0000, 6'd16, 1'b1, 1'b0, CHK_TEXT,      "80000000"},
    '{32'hFFFF_FFFF, 6'd16, 1'b0, 1'b0, CHK_TEXT,      "ffffffff"},
    '{32'hFFFF_FFFF, 6'd2,  1'b0, 1'b0, CHK_PREDICT,   ""},
    '{32'h0000_0001, 6'd2,  1'b1, 1'b0, CHK_TEXT,      "1"},
    '{32'h0000_0023, 6'd36, 1'b0, 1'b0, CHK_TEXT,      "z"},
    '{32'h0000_0024, 6'd36, 1'b0, 1'b0, CHK_TEXT,      "10"},
    '{32'hFFFF_FFFF, 6'd36, 1'b1, 1'b0, CHK_PREDICT,   ""},
    '{32'h0000_00FF, 6'd8,  1'b0, 1'b0, CHK_TEXT,      "377"},
    '{32'h0000_000A, 6'd11, 1'b0, 1'b0, CHK_TEXT,      "a"},
    '{32'hDEAD_BEEF, 6'd10, 1'b1, 1'b0, CHK_PREDICT,   ""},
    '{32'h1234_5678, 6'd7,  1'b1, 1'b0, CHK_PREDICT,   ""},
    '{32'h0000_0005, 6'd0,  1'b0, 1'b0, CHK_BAD_RADIX, ""},
    '{32'h0000_0005, 6'd1,  1'b1, 1'b0, CHK_BAD_RADIX, ""},
    '{32'h0000_0000, 6'd37, 1'b0, 1'b0, CHK_BAD_RADIX, ""},
    '{32'hFFFF_FFFF, 6'd63, 1'b1, 1'b0, CHK_BAD_RADIX, ""},
    '{32'hFFFF_FFFF, 6'd16, 1'b0, 1'b1, CHK_TEXT,      "FFFFFFFF"},
    '{32'h0000_0023, 6'd36, 1'b0, 1'b1, CHK_TEXT,      "Z"}
  };

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  in_t   in_beat   = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_beat;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic  cfg_data  = 1'b0;

  // Characters still owed by the block, oldest first
  out_t        char_q[$];
  logic        upper_now     = 1'b0;
  bit          quiet         = 1'b0;
  bit          hold_req      = 1'b0;
  int unsigned errors        = 0;
  int unsigned numbers       = 0;
  int unsigned flagged       = 0;
  int unsigned chars_checked = 0;

  integer_to_radix_text dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_beat),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  // Text of one number: sign, then digits most significant first
  function automatic void predict_chars(in_t num);
    logic [31:0] mag;
    logic [5:0]  digits[$];
    logic [5:0]  d;
    logic        neg;
    logic [7:0]  letter_a;
    out_t        c;
    int unsigned r;
    int          i;
    if (num.radix < RADIX_MIN || num.radix > RADIX_MAX) begin
      c.char_code = CH_NONE;
      c.last      = 1'b1;
      c.bad_radix = 1'b1;
      char_q.push_back(c);
      return;
    end
    r        = 32'(num.radix);
    letter_a = upper_now ? CH_UPPER_A : CH_LOWER_A;
    neg      = num.signed_mode && (num.radix == RADIX_DEC) && num.value[31];
    mag      = neg ? 32'(0 - num.value) : num.value;
    // divide down, least significant digit first
    do begin
      digits.push_back(6'(mag % r));
      mag = mag / r;
    end while (mag != 0 && digits.size() < MAX_DIGITS);
    c.bad_radix = 1'b0;
    if (neg) begin
      c.char_code = CH_MINUS;
      c.last      = 1'b0;
      char_q.push_back(c);
    end
    for (i = digits.size() - 1; i >= 0; i--) begin
      d           = digits[i];
      c.char_code = (d > DIGIT_MAX) ? 8'(letter_a + d - DIGIT_MAX - 1) : 8'(CH_ZERO + d);
      c.last      = (i == 0);
      char_q.push_back(c);
    end
  endfunction

  // Offer one number, wait for its beat, then record what it owes
  task automatic send_number(in_t num, chk_kind_e kind, string text);
    int unsigned gap;
    int          i;
    out_t        c;
    gap = 0;
    if (!quiet)
      while ($urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= num;
    do @(posedge clk); while (!in_ready);
    numbers++;
    if (num.radix < RADIX_MIN || num.radix > RADIX_MAX) flagged++;
    case (kind)
      CHK_TEXT: begin
        for (i = 0; i < text.len(); i++) begin
          c.char_code = text[i];
          c.last      = (i == text.len() - 1);
          c.bad_radix = 1'b0;
          char_q.push_back(c);
        end
      end
      CHK_BAD_RADIX: begin
        c.char_code = CH_NONE;
        c.last      = 1'b1;
        c.bad_radix = 1'b1;
        char_q.push_back(c);
      end
      default: predict_chars(num);
    endcase
  endtask

  // Stop offering and wait until every owed character has come out
  task automatic settle_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (char_q.size() != 0);
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  task automatic write_case(logic upper);
    cfg_valid <= 1'b1;
    cfg_data  <= upper;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    upper_now = upper;
  endtask

  // Random number: mostly valid radixes, values biased to extremes and digit boundaries
  function automatic in_t rand_number();
    in_t         num;
    logic [63:0] p;
    int unsigned r;
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      num.radix = $urandom_range(0, 1) ? 6'($urandom_range(0, 1)) : 6'($urandom_range(37, 63));
    else if (pick < 35) num.radix = RADIX_DEC;
    else if (pick < 50) num.radix = 6'd16;
    else if (pick < 60) num.radix = RADIX_MIN;
    else if (pick < 65) num.radix = RADIX_MAX;
    else num.radix = 6'($urandom_range(2, 36));
    r = 32'(num.radix);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: num.value = $urandom();
      4, 5: num.value = $urandom_range(0, (r + 1) * (r + 1) * (r + 1));
      6: begin
        case ($urandom_range(0, 4))
          0: num.value = 32'h0000_0000;
          1: num.value = 32'hFFFF_FFFF;
          2: num.value = 32'h8000_0000;
          3: num.value = 32'h7FFF_FFFF;
          default: num.value = 32'h0000_0001;
        endcase
      end
      7: begin
        // a power of the radix, or one below it
        p = 1;
        n = $urandom_range(1, 32);
        repeat (n) if (p * r <= 64'hFFFF_FFFF) p = p * r;
        num.value = 32'(p - $urandom_range(0, 1));
      end
      default: num.value = $urandom() >> $urandom_range(0, 31);
    endcase
    num.signed_mode = 1'($urandom_range(0, 1));
    return num;
  endfunction

  // Output side: check each beat, then pick ready for the next cycle
  initial begin : char_sink
    out_t        want;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (char_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected beat char %h last %b bad_radix %b", $time,
                     out_beat.char_code, out_beat.last, out_beat.bad_radix);
        end else begin
          want = char_q.pop_front();
          chars_checked++;
          if (out_beat.char_code !== want.char_code || out_beat.last !== want.last ||
              out_beat.bad_radix !== want.bad_radix) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: expected char %h last %b bad %b, got char %h last %b bad %b",
                       $time, want.char_code, want.last, want.bad_radix,
                       out_beat.char_code, out_beat.last, out_beat.bad_radix);
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Input side: reset, directed rows, then random phases
  initial begin : number_source
    in_t         num;
    dir_row_t    row;
    int unsigned i;
    int unsigned ph;
    int unsigned k;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) begin
      row = dir_rows[i];
      if (row.upper != upper_now) begin
        settle_idle();
        write_case(row.upper);
      end
      num.value       = row.value;
      num.radix       = row.radix;
      num.signed_mode = row.signed_mode;
      send_number(num, row.kind, row.text);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle_idle();
      write_case(ph == 0 ? 1'b0 : (ph == 1 ? 1'b1 : 1'($urandom_range(0, 1))));
      quiet = (ph == 1);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // long output stall while numbers keep coming
        if (ph == 2 && k == 10) hold_req = 1'b1;
        // sender pause until the block has drained
        if (ph == 3 && k == 25) settle_idle();
        send_number(rand_number(), CHK_PREDICT, "");
      end
    end
    quiet = 1'b0;

    settle_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Converted %0d numbers (%0d with an out-of-range radix), checked %0d characters",
             numbers, flagged, chars_checked);
    $display("Covered signed and unsigned input, radixes 0..63, both letter cases, output hold-off");
    if (errors == 0 && char_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
